// File: sv/rqcq_pkg.sv
`default_nettype none

package rqcq_pkg;

    // queue geometry
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // request codes
    localparam logic [2:0] REQ_PUSH    = 3'd0;
    localparam logic [2:0] REQ_POP     = 3'd1;
    localparam logic [2:0] REQ_ABOVE   = 3'd2;
    localparam logic [2:0] REQ_EVEN_NZ = 3'd3;
    localparam logic [2:0] REQ_REVERSE = 3'd4;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] push_value;
        logic signed [DATA_W-1:0] threshold;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [CNT_W-1:0]         match_count;
        logic [1:0]               status;
        logic                     is_empty;
        logic [CNT_W-1:0]         occupancy;
    } rsp_t;

    // physical slot of the entry at a given offset from the head
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W+1)'(DEPTH)) begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/rqcq_ram.sv
`default_nettype none

module rqcq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port; read data holds between reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/ring_queue_with_content_queries.sv
`default_nettype none

// channel   ports                        payload
// -------   --------------------------   ---------------------------------------
// request   s_valid, s_ready, s_req      req_type, push_value, threshold
// result    m_valid, m_ready, m_rsp      pop_value, match_count, status,
//                                        is_empty, occupancy
//
// one request at a time. push, pop, unknown codes and a reverse of up to one entry go
// from acceptance straight to the commit step; a count query first reads each stored
// entry in turn, and a longer reverse swaps pairs from both ends inward before it commits.
// synchronous active-low reset clears head, count and control; no memory sweep.
// a new request is taken while a result waits in the output register; a
// finished request holds in its last step until that register is free.

module ring_queue_with_content_queries (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rqcq_pkg::req_t s_req,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rqcq_pkg::rsp_t     m_rsp
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CNT  = 3'd1;
    localparam logic [2:0] ST_RA   = 3'd2;
    localparam logic [2:0] ST_RB   = 3'd3;
    localparam logic [2:0] ST_WA   = 3'd4;
    localparam logic [2:0] ST_WB   = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]                          state_reg, state_next;
    rqcq_pkg::req_t                      req_reg, req_next;
    logic [rqcq_pkg::ADDR_W-1:0]         head_reg, head_next;
    logic [rqcq_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [rqcq_pkg::ADDR_W-1:0]         idx_reg, idx_next;
    logic [rqcq_pkg::ADDR_W-1:0]         hi_reg, hi_next;
    logic [rqcq_pkg::DATA_W-1:0]         tmp_reg, tmp_next;
    logic [rqcq_pkg::CNT_W-1:0]          match_reg, match_next;
    logic                                m_valid_reg, m_valid_next;
    rqcq_pkg::rsp_t                      m_rsp_reg, m_rsp_next;

    logic                                ram_wr_en;
    logic [rqcq_pkg::ADDR_W-1:0]         ram_wr_addr;
    logic [rqcq_pkg::DATA_W-1:0]         ram_wr_data;
    logic                                ram_rd_en;
    logic [rqcq_pkg::ADDR_W-1:0]         ram_rd_addr;
    logic [rqcq_pkg::DATA_W-1:0]         ram_rd_data;

    logic                                accept;
    logic                                out_free;
    logic                                hit;
    logic                                more_pairs;
    logic                                more_entries;

    rqcq_ram #(
        .WIDTH (rqcq_pkg::DATA_W),
        .DEPTH (rqcq_pkg::DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_rsp    = m_rsp_reg;

    // match test on the entry just read
    always_comb begin
        case (req_reg.req_type)
            rqcq_pkg::REQ_ABOVE:
                hit = ($signed(ram_rd_data) > req_reg.threshold);
            rqcq_pkg::REQ_EVEN_NZ:
                hit = !ram_rd_data[0] && (ram_rd_data != '0);
            default:
                hit = 1'b0;
        endcase
    end

    // walk conditions: another entry to read, another pair to swap
    assign more_entries = (({1'b0, idx_reg} + 1'b1) < count_reg);
    assign more_pairs   = (({1'b0, idx_reg} + 2'd2) < {1'b0, hi_reg});

    // sequencer
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        hi_next      = hi_reg;
        tmp_next     = tmp_reg;
        match_next   = match_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rsp_next   = m_rsp_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = rqcq_pkg::slot_of(head_reg, idx_reg);
        ram_wr_data  = tmp_reg;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = rqcq_pkg::slot_of(head_reg, idx_reg);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next   = s_req;
                    idx_next   = '0;
                    hi_next    = rqcq_pkg::ADDR_W'(count_reg - 1'b1);
                    match_next = '0;
                    state_next = ST_FIN;
                    case (s_req.req_type)
                        rqcq_pkg::REQ_POP: begin
                            ram_rd_en   = (count_reg != '0);
                            ram_rd_addr = head_reg;
                        end
                        rqcq_pkg::REQ_ABOVE, rqcq_pkg::REQ_EVEN_NZ: begin
                            if (count_reg != '0) begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = head_reg;
                                state_next  = ST_CNT;
                            end
                        end
                        rqcq_pkg::REQ_REVERSE: begin
                            if (count_reg > (rqcq_pkg::CNT_W)'(1)) begin
                                state_next = ST_RA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // one stored entry per cycle, next read issued alongside
            ST_CNT: begin
                match_next = match_reg + rqcq_pkg::CNT_W'(hit);
                if (more_entries) begin
                    idx_next    = idx_reg + 1'b1;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rqcq_pkg::slot_of(head_reg, idx_reg + 1'b1);
                end else begin
                    state_next = ST_FIN;
                end
            end

            // prologue: read low entry of the first pair
            ST_RA: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = rqcq_pkg::slot_of(head_reg, idx_reg);
                state_next  = ST_RB;
            end

            // keep low entry, read high entry
            ST_RB: begin
                tmp_next    = ram_rd_data;
                ram_rd_en   = 1'b1;
                ram_rd_addr = rqcq_pkg::slot_of(head_reg, hi_reg);
                state_next  = ST_WA;
            end

            // high value into low slot, read next low entry
            ST_WA: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = rqcq_pkg::slot_of(head_reg, idx_reg);
                ram_wr_data = ram_rd_data;
                if (more_pairs) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rqcq_pkg::slot_of(head_reg, idx_reg + 1'b1);
                end
                state_next = ST_WB;
            end

            // low value into high slot, read next high entry
            ST_WB: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = rqcq_pkg::slot_of(head_reg, hi_reg);
                ram_wr_data = tmp_reg;
                if (more_pairs) begin
                    tmp_next    = ram_rd_data;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rqcq_pkg::slot_of(head_reg, hi_reg - 1'b1);
                    idx_next    = idx_reg + 1'b1;
                    hi_next     = hi_reg - 1'b1;
                    state_next  = ST_WA;
                end else begin
                    state_next = ST_FIN;
                end
            end

            // commit and load the result register
            ST_FIN: begin
                if (out_free) begin
                    m_rsp_next             = '0;
                    m_rsp_next.status      = rqcq_pkg::STS_OK;
                    case (req_reg.req_type)
                        rqcq_pkg::REQ_PUSH: begin
                            if (count_reg == (rqcq_pkg::CNT_W)'(rqcq_pkg::DEPTH)) begin
                                m_rsp_next.status = rqcq_pkg::STS_FULL;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = rqcq_pkg::slot_of(head_reg,
                                                  rqcq_pkg::ADDR_W'(count_reg));
                                ram_wr_data = req_reg.push_value;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        rqcq_pkg::REQ_POP: begin
                            if (count_reg == '0) begin
                                m_rsp_next.status = rqcq_pkg::STS_EMPTY;
                            end else begin
                                m_rsp_next.pop_value = ram_rd_data;
                                head_next  = rqcq_pkg::slot_of(head_reg,
                                                 rqcq_pkg::ADDR_W'(1));
                                count_next = count_reg - 1'b1;
                            end
                        end
                        rqcq_pkg::REQ_ABOVE, rqcq_pkg::REQ_EVEN_NZ: begin
                            m_rsp_next.match_count = match_reg;
                        end
                        default: begin
                        end
                    endcase
                    m_rsp_next.occupancy = count_next;
                    m_rsp_next.is_empty  = (count_next == '0);
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        hi_reg    <= hi_next;
        tmp_reg   <= tmp_next;
        match_reg <= match_next;
        m_rsp_reg <= m_rsp_next;
    end

    // occupancy never passes the ring depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (rqcq_pkg::CNT_W)'(rqcq_pkg::DEPTH))
        else $error("occupancy beyond depth");

    // a refused push is only reported on a full ring
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_rsp.status == rqcq_pkg::STS_FULL)
        |-> m_rsp.occupancy == (rqcq_pkg::CNT_W)'(rqcq_pkg::DEPTH))
        else $error("full status with room left");

    // empty flag agrees with reported occupancy
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rsp.is_empty == (m_rsp.occupancy == '0)))
        else $error("empty flag mismatch");

    // count queries never write the ring
    a_query_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CNT) |-> !ram_wr_en)
        else $error("write during count walk");

    // an accepted request leaves idle for at least one step
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
        else $error("request accepted without processing");

endmodule

`default_nettype wire

// File: tb/ring_queue_checker.sv
`timescale 1ns / 1ps

module ring_queue_checker
    import rqcq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic s_ready,
    input  wire req_t s_req,
    input  wire logic m_valid,
    input  wire logic m_ready,
    input  wire rsp_t m_rsp,
    output int        err_count,
    output int        outstanding,
    output int        results_checked,
    output int        refused_pushes,
    output int        refused_pops
);

    // shadow copy of the ring
    logic signed [DATA_W-1:0] shadow_ring [DEPTH];
    int                       shadow_head;
    int                       shadow_fill;

    // results owed for requests already taken, oldest first
    rsp_t awaited_rsp [$];
    rsp_t oldest;

    initial begin
        err_count       = 0;
        outstanding     = 0;
        results_checked = 0;
        refused_pushes  = 0;
        refused_pops    = 0;
        shadow_head     = 0;
        shadow_fill     = 0;
    end

    // physical slot of the entry a given distance from the head
    function automatic int ring_pos(input int off);
        return (shadow_head + off) % DEPTH;
    endfunction

    // apply one request to the shadow ring and return the result it should give
    function automatic rsp_t apply_request(input req_t r);
        rsp_t                     res;
        logic [CNT_W-1:0]         hits;
        logic signed [DATA_W-1:0] word;
        logic signed [DATA_W-1:0] bound;
        int                       a;
        int                       b;
        res   = '0;
        hits  = '0;
        bound = r.threshold;
        case (r.req_type)
            REQ_PUSH: begin
                if (shadow_fill == DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    shadow_ring[ring_pos(shadow_fill)] = r.push_value;
                    shadow_fill++;
                end
            end
            REQ_POP: begin
                if (shadow_fill == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    res.pop_value = shadow_ring[shadow_head];
                    shadow_head   = (shadow_head + 1) % DEPTH;
                    shadow_fill--;
                end
            end
            REQ_ABOVE: begin
                for (int i = 0; i < shadow_fill; i++) begin
                    word = shadow_ring[ring_pos(i)];
                    if (word > bound) hits++;
                end
            end
            REQ_EVEN_NZ: begin
                // bit 0 clear means even, negative words included
                for (int i = 0; i < shadow_fill; i++) begin
                    word = shadow_ring[ring_pos(i)];
                    if (!word[0] && word != 0) hits++;
                end
            end
            REQ_REVERSE: begin
                for (int i = 0; i < shadow_fill / 2; i++) begin
                    a    = ring_pos(i);
                    b    = ring_pos(shadow_fill - 1 - i);
                    word = shadow_ring[a];
                    shadow_ring[a] = shadow_ring[b];
                    shadow_ring[b] = word;
                end
            end
            default: begin
                // unused codes leave everything alone
            end
        endcase
        res.match_count = hits;
        res.is_empty    = (shadow_fill == 0);
        res.occupancy   = CNT_W'(shadow_fill);
        return res;
    endfunction

    task automatic check_field(input string fname, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            err_count++;
        end
    endtask

    // compare results first: a result can never belong to a request taken at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            awaited_rsp.delete();
            shadow_head = 0;
            shadow_fill = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_rsp.size() == 0) begin
                    $error("result 0x%0h arrived with no request waiting", m_rsp);
                    err_count++;
                end else begin
                    oldest = awaited_rsp.pop_front();
                    check_field("pop_value", oldest.pop_value, m_rsp.pop_value);
                    check_field("match_count", oldest.match_count, m_rsp.match_count);
                    check_field("status", oldest.status, m_rsp.status);
                    check_field("is_empty", oldest.is_empty, m_rsp.is_empty);
                    check_field("occupancy", oldest.occupancy, m_rsp.occupancy);
                    results_checked++;
                end
            end
            if (s_valid && s_ready) begin
                oldest = apply_request(s_req);
                if (oldest.status == STS_FULL) refused_pushes++;
                if (oldest.status == STS_EMPTY) refused_pops++;
                awaited_rsp.push_back(oldest);
            end
        end
        outstanding = awaited_rsp.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import rqcq_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS   = 150;
    localparam int EPOCH_LEN    = 30;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 40;

    // request codes the block does not define
    localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] REQ_MID_UNUSED   = 3'd6;
    localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;

    localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_req;
    logic m_valid;
    logic m_ready;
    rsp_t m_rsp;

    int err_count;
    int outstanding;
    int results_checked;
    int refused_pushes;
    int refused_pops;

    bit                       idle_on = 1'b1;
    int                       cycle_count = 0;
    int                       issued [8];
    logic signed [DATA_W-1:0] last_pushed = '0;

    always #6 aclk = ~aclk;

    ring_queue_with_content_queries dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    ring_queue_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req           (s_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rsp           (m_rsp),
        .err_count       (err_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .refused_pushes  (refused_pushes),
        .refused_pops    (refused_pops)
    );

    // hard stop if the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL ring_queue_with_content_queries");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                repeat ($urandom_range(1, 24)) @(negedge aclk);
            end
        end
    end

    function automatic req_t make_req(input logic [2:0] kind,
                                      input logic signed [DATA_W-1:0] value,
                                      input logic signed [DATA_W-1:0] bound);
        req_t r;
        r.req_type   = kind;
        r.push_value = value;
        r.threshold  = bound;
        return r;
    endfunction

    // word mix: extremes, zero, small values, even words and full random
    function automatic logic signed [DATA_W-1:0] pick_word();
        int near;
        near = $urandom_range(0, 20);
        case ($urandom_range(0, 7))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return near - 10;
            4:       return $urandom & ~32'd1;
            default: return $urandom;
        endcase
    endfunction

    // mode 0 fills, mode 1 drains, mode 2 mixes
    function automatic req_t random_req(input int mode);
        int                       roll;
        int                       push_cut;
        int                       pop_cut;
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] bound;
        req_t                     r;
        roll     = $urandom_range(0, 99);
        push_cut = (mode == 0) ? 60 : (mode == 1) ? 10 : 35;
        pop_cut  = push_cut + ((mode == 0) ? 10 : (mode == 1) ? 60 : 30);
        if (roll < push_cut) begin
            kind = REQ_PUSH;
        end else if (roll < pop_cut) begin
            kind = REQ_POP;
        end else if (roll < 97) begin
            case ($urandom_range(0, 2))
                0:       kind = REQ_ABOVE;
                1:       kind = REQ_EVEN_NZ;
                default: kind = REQ_REVERSE;
            endcase
        end else begin
            kind = 3'($urandom_range(int'(REQ_FIRST_UNUSED), int'(REQ_LAST_UNUSED)));
        end
        // thresholds often sit right on or just under a stored word
        case ($urandom_range(0, 4))
            0:       bound = last_pushed;
            1:       bound = last_pushed - 1;
            default: bound = pick_word();
        endcase
        r = make_req(kind, pick_word(), bound);
        if (kind == REQ_PUSH) last_pushed = r.push_value;
        return r;
    endfunction

    // present one request, with an optional gap first, and wait for it to be taken
    task automatic issue(input req_t r);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_req   = r;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        issued[r.req_type]++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    initial begin
        int   effective;
        int   epoch;
        req_t r;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_req     = '0;
        effective = 0;
        epoch     = 0;
        foreach (issued[k]) issued[k] = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // empty queue corner cases
        issue(make_req(REQ_POP, 32'd5, 32'd0));
        issue(make_req(REQ_ABOVE, 32'd0, WORD_MIN));
        issue(make_req(REQ_EVEN_NZ, 32'd0, 32'd0));
        issue(make_req(REQ_REVERSE, 32'd0, 32'd0));
        // unused codes are no-ops even with live payloads
        issue(make_req(REQ_FIRST_UNUSED, WORD_MAX, WORD_MIN));
        issue(make_req(REQ_MID_UNUSED, 32'hA5A5_5A5A, 32'h5A5A_A5A5));
        issue(make_req(REQ_LAST_UNUSED, WORD_MIN, WORD_MAX));
        // single entry reverse, then extremes, zero and even/odd words
        issue(make_req(REQ_PUSH, WORD_MIN, 32'd0));
        issue(make_req(REQ_REVERSE, 32'd0, 32'd0));
        issue(make_req(REQ_PUSH, WORD_MAX, 32'd0));
        issue(make_req(REQ_PUSH, 32'd0, 32'd0));
        issue(make_req(REQ_PUSH, -32'sd2, 32'd0));
        issue(make_req(REQ_PUSH, 32'd2, 32'd0));
        issue(make_req(REQ_PUSH, 32'd1, 32'd0));
        issue(make_req(REQ_ABOVE, 32'd0, WORD_MIN));
        issue(make_req(REQ_ABOVE, 32'd0, WORD_MAX));
        issue(make_req(REQ_ABOVE, 32'd0, -32'sd1));
        issue(make_req(REQ_ABOVE, 32'd0, 32'd0));
        issue(make_req(REQ_EVEN_NZ, 32'd0, 32'd0));
        issue(make_req(REQ_REVERSE, 32'd0, 32'd0));
        issue(make_req(REQ_POP, 32'd0, 32'd0));
        issue(make_req(REQ_POP, 32'd0, 32'd0));
        issue(make_req(REQ_POP, 32'd0, 32'd0));
        drain_results();

        // random epochs cycling through fill, drain and mixed traffic
        while (effective < RANDOM_ITEMS) begin
            if (effective >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
            repeat (EPOCH_LEN) begin
                r = random_req(epoch % 3);
                issue(r);
                if (r.req_type <= REQ_REVERSE) effective++;
            end
            // hold off the sender now and then until the pipe is empty
            if (epoch % 3 == 1 && $urandom_range(0, 1) == 0) drain_results();
            epoch++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("covered %0d push, %0d pop, %0d above, %0d even-nonzero, %0d reverse requests",
                 issued[REQ_PUSH], issued[REQ_POP], issued[REQ_ABOVE], issued[REQ_EVEN_NZ],
                 issued[REQ_REVERSE]);
        $display("%0d results checked, %0d pushes refused when full, %0d pops refused when empty",
                 results_checked, refused_pushes, refused_pops);
        if (err_count == 0) begin
            $display("PASS ring_queue_with_content_queries");
        end else begin
            $display("FAIL ring_queue_with_content_queries");
        end
        $finish;
    end

endmodule
